FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the msth_chk checker file
// Clocked property checks with an active-low disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released
`define CHK_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("property check failed");

// Check that a condition leads to a consequence in the next cycle
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/msth_pkg.sv
// ----------------------------------------------------------------------------
// msth_pkg
// Types, constants and helper functions of the mid-square hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package msth_pkg;

	localparam int KEY_W     = 16;
	localparam int PAIR_W    = 10;
	localparam int BKT_W     = 11;
	localparam int POS_W     = 3;
	localparam int LEN_W     = 4;
	localparam int HASH_W    = 10;
	localparam int SQ_W      = 32;
	localparam int NBUCKETS  = 2048;
	localparam int NSLOTS    = 16384;
	localparam logic [PAIR_W-1:0] PAIRS_RESET = 10'd11;
	localparam logic [KEY_W-1:0]  KEY_LIMIT   = 16'd46340;
	// floor(x/10) = (x * RECIP10) >> 35 for any 32-bit x
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP_SH = 35;
	localparam logic [3:0] MAX_DIGITS = 4'd10;

	typedef enum logic [2:0] {
		ST_INS   = 3'd0,
		ST_FOUND = 3'd1,
		ST_MISS  = 3'd2,
		ST_FULL  = 3'd3,
		ST_BIG   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SQ, S_NDIG, S_DROP, S_DROPQ, S_DIG, S_DIGQ,
		S_LA, S_LB, S_LW, S_INS, S_SRD, S_SCMP, S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic count;
		logic start_div;
		logic mul;
		logic drop_upd;
		logic dig_upd;
		logic rd_b;
		logic cap_a;
		logic cap_b;
		logic insert;
		logic scmp;
		logic clr_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic too_large;
		logic search;
		logic cnt_more;
		logic drop_zero;
		logic dig_zero;
		logic hit;
		logic step_last;
		logic clr_last;
		logic out_free;
	} sts_t;

	// Powers of ten used by the digit count of the square
	function automatic logic [SQ_W-1:0] pow10(input logic [3:0] n);
		logic [SQ_W-1:0] r;
		unique case (n)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = '1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/mid_square_two_choice_hash_table.sv
// A rejected key goes from the accepting edge straight to the result state; an insert
// squares the key, counts its digits, drops and takes digits, reads both chain lengths
// and writes the key, while a search scans the key slots instead. The next word is taken
// the cycle after the result is loaded, and a stalled result word holds the input off.
// The decimal digit unit and the key memory read port (up to sixteen slots) set how long
// a request takes. After reset all 2048 chain lengths clear; bucket_pairs resets to 11.
// ----------------------------------------------------------------------------
// mid_square_two_choice_hash_table
// Two-choice chained key table addressed by a decimal mid-square hash.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_square_two_choice_hash_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // key
	input  wire logic        s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // status[2:0], hash_value[12:3],
	                                    // bucket_index[23:13], chain_position[26:24]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data   // bucket_pairs
);

	msth_pkg::cmd_t cmd;
	msth_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	msth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msth_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

FILE: design/msth_ram.sv
// ----------------------------------------------------------------------------
// msth_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module msth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/msth_dp.sv
// ----------------------------------------------------------------------------
// msth_dp
// Datapath: squaring, decimal digit unit, chain length and key memories,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msth_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire msth_pkg::cmd_t       cmd,
	output msth_pkg::sts_t            sts,
	input  wire logic [15:0]          s_tdata,   // key
	input  wire logic                 s_tuser,   // req_type
	input  wire logic                 cfg_valid,
	input  wire logic [9:0]           cfg_data,  // bucket_pairs
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata    // status, hash_value, bucket_index,
	                                             // chain_position, zero pad
);

	logic [msth_pkg::PAIR_W-1:0] bp_q;
	logic                        m_tvalid_q;
	logic [msth_pkg::BKT_W-1:0]  clr_q;

	logic [msth_pkg::KEY_W-1:0]  key_q;
	logic [msth_pkg::SQ_W-1:0]   sq_q;
	logic [3:0]                  nsq_q;
	logic [63:0]                 prod_q;
	logic [2:0]                  drop_q;
	logic [1:0]                  dig_q;
	logic [1:0]                  wsel_q;
	logic [msth_pkg::HASH_W-1:0] hash_q;
	logic [msth_pkg::LEN_W-1:0]  lena_q;
	logic [msth_pkg::LEN_W-1:0]  lenb_q;
	logic [3:0]                  step_q;
	msth_pkg::status_t           res_st_q;
	logic [msth_pkg::BKT_W-1:0]  res_bi_q;
	logic [msth_pkg::POS_W-1:0]  res_cp_q;
	logic [26:0]                 out_q;

	logic [msth_pkg::PAIR_W-1:0] pairs;
	logic [3:0]                  nd;
	logic [3:0]                  diff;
	logic [3:0]                  half;
	logic [28:0]                 quo;
	logic [31:0]                 q10;
	logic [3:0]                  rem;
	logic [msth_pkg::HASH_W-1:0] dig_w;
	logic [msth_pkg::BKT_W-1:0]  addr_a;
	logic [msth_pkg::BKT_W-1:0]  addr_b;
	logic [msth_pkg::BKT_W-1:0]  idx;
	logic [msth_pkg::LEN_W-1:0]  pos;
	logic                        full;
	logic                        ins_ok;
	logic [msth_pkg::BKT_W-1:0]  scan_bkt;
	logic [msth_pkg::LEN_W-1:0]  scan_len;
	logic                        hit;
	logic                        len_we;
	logic [msth_pkg::BKT_W-1:0]  len_waddr;
	logic [msth_pkg::LEN_W-1:0]  len_wdata;
	logic [msth_pkg::BKT_W-1:0]  len_raddr;
	logic [msth_pkg::LEN_W-1:0]  len_rd;
	logic [msth_pkg::KEY_W-1:0]  key_rd;

	// Geometry from the pair count
	always_comb begin
		pairs = {bp_q[9:1], 1'b1};
		if (pairs >= 10'd1000) begin
			nd = 4'd4;
		end else if (pairs >= 10'd100) begin
			nd = 4'd3;
		end else if (pairs >= 10'd10) begin
			nd = 4'd2;
		end else begin
			nd = 4'd1;
		end
		diff   = (nsq_q > nd) ? (nsq_q - nd) : 4'd0;
		half   = (diff + 4'd1) >> 1;
		addr_a = {1'b0, hash_q};
		addr_b = {1'b0, hash_q} + {1'b0, pairs};
	end

	// Divide by ten from the registered reciprocal product
	always_comb begin
		quo = prod_q[63:msth_pkg::RECIP_SH];
		q10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
		rem = 4'(sq_q - q10);
		unique case (wsel_q)
			2'd0:    dig_w = {6'd0, rem};
			2'd1:    dig_w = 10'({6'd0, rem} * 10'd10);
			2'd2:    dig_w = 10'({6'd0, rem} * 10'd100);
			default: dig_w = '0;
		endcase
	end

	// Insert choice: empty primary, empty partner, else shorter chain
	always_comb begin
		if (lena_q == '0) begin
			idx = addr_a;
			pos = lena_q;
		end else if (lenb_q == '0) begin
			idx = addr_b;
			pos = lenb_q;
		end else if (lena_q > lenb_q) begin
			idx = addr_b;
			pos = lenb_q;
		end else begin
			idx = addr_a;
			pos = lena_q;
		end
		full   = pos[3];
		ins_ok = cmd.insert && !full;
	end

	// Scan slot select and compare
	always_comb begin
		scan_bkt = step_q[0] ? addr_b : addr_a;
		scan_len = step_q[0] ? lenb_q : lena_q;
		hit      = (key_rd == key_q) && ({1'b0, step_q[3:1]} < scan_len);
	end

	// Memory port selection
	always_comb begin
		len_we    = cmd.clr_wr || ins_ok;
		len_waddr = cmd.clr_wr ? clr_q : idx;
		len_wdata = cmd.clr_wr ? '0 : pos + 4'd1;
		len_raddr = cmd.rd_b ? addr_b : addr_a;
	end

	msth_ram #(
		.WIDTH (msth_pkg::LEN_W),
		.DEPTH (msth_pkg::NBUCKETS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rd)
	);

	msth_ram #(
		.WIDTH (msth_pkg::KEY_W),
		.DEPTH (msth_pkg::NSLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (ins_ok),
		.waddr ({idx, pos[2:0]}),
		.wdata (key_q),
		.raddr ({scan_bkt, step_q[3:1]}),
		.rdata (key_rd)
	);

	// Control registers: config, clear sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q       <= msth_pkg::PAIRS_RESET;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bp_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 11'd1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= s_tdata;
			hash_q   <= '0;
			res_bi_q <= '0;
			res_cp_q <= '0;
			step_q   <= '0;
			if (s_tdata > msth_pkg::KEY_LIMIT) begin
				res_st_q <= msth_pkg::ST_BIG;
			end else if (s_tuser) begin
				res_st_q <= msth_pkg::ST_MISS;
			end else begin
				res_st_q <= msth_pkg::ST_FULL;
			end
		end
		if (cmd.square) begin
			sq_q  <= {16'd0, key_q} * {16'd0, key_q};
			nsq_q <= '0;
		end
		if (cmd.count) begin
			nsq_q <= nsq_q + 4'd1;
		end
		if (cmd.start_div) begin
			drop_q <= half[2:0];
			dig_q  <= 2'(nd - 4'd1);
			wsel_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= {32'd0, sq_q} * {32'd0, msth_pkg::RECIP10};
		end
		if (cmd.drop_upd) begin
			sq_q   <= {3'd0, quo};
			drop_q <= drop_q - 3'd1;
		end
		if (cmd.dig_upd) begin
			sq_q   <= {3'd0, quo};
			hash_q <= hash_q + dig_w;
			dig_q  <= dig_q - 2'd1;
			wsel_q <= wsel_q + 2'd1;
		end
		if (cmd.cap_a) begin
			lena_q <= len_rd;
		end
		if (cmd.cap_b) begin
			lenb_q <= len_rd;
		end
		if (ins_ok) begin
			res_st_q <= msth_pkg::ST_INS;
			res_bi_q <= idx;
			res_cp_q <= pos[2:0];
		end
		if (cmd.scmp) begin
			if (hit) begin
				res_st_q <= msth_pkg::ST_FOUND;
				res_bi_q <= scan_bkt;
				res_cp_q <= step_q[3:1];
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
		if (cmd.out_load) begin
			out_q <= {res_cp_q, res_bi_q, hash_q, res_st_q};
		end
	end

	// Status back to the controller
	always_comb begin
		sts.too_large = s_tdata > msth_pkg::KEY_LIMIT;
		sts.search    = s_tuser;
		sts.cnt_more  = (nsq_q < msth_pkg::MAX_DIGITS) && (sq_q >= msth_pkg::pow10(nsq_q));
		sts.drop_zero = drop_q == '0;
		sts.dig_zero  = dig_q == '0;
		sts.hit       = hit;
		sts.step_last = &step_q;
		sts.clr_last  = &clr_q;
		sts.out_free  = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_q};

endmodule

`default_nettype wire

FILE: design/msth_ctrl.sv
// ----------------------------------------------------------------------------
// msth_ctrl
// Controller: sequences clear sweep, hashing, chain access and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module msth_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire msth_pkg::sts_t sts,
	output msth_pkg::cmd_t      cmd
);

	msth_pkg::state_t state_q;
	msth_pkg::state_t state_d;
	logic             search_q;
	logic             search_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msth_pkg::S_CLEAR;
			search_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			search_q <= search_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		search_d = search_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			msth_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = msth_pkg::S_IDLE;
				end
			end
			msth_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					search_d = sts.search;
					state_d  = sts.too_large ? msth_pkg::S_OUT : msth_pkg::S_SQ;
				end
			end
			msth_pkg::S_SQ: begin
				cmd.square = 1'b1;
				state_d    = msth_pkg::S_NDIG;
			end
			msth_pkg::S_NDIG: begin
				if (sts.cnt_more) begin
					cmd.count = 1'b1;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = msth_pkg::S_DROP;
				end
			end
			msth_pkg::S_DROP: begin
				if (sts.drop_zero) begin
					state_d = msth_pkg::S_DIG;
				end else begin
					cmd.mul = 1'b1;
					state_d = msth_pkg::S_DROPQ;
				end
			end
			msth_pkg::S_DROPQ: begin
				cmd.drop_upd = 1'b1;
				state_d      = msth_pkg::S_DROP;
			end
			msth_pkg::S_DIG: begin
				if (sts.dig_zero) begin
					state_d = msth_pkg::S_LA;
				end else begin
					cmd.mul = 1'b1;
					state_d = msth_pkg::S_DIGQ;
				end
			end
			msth_pkg::S_DIGQ: begin
				cmd.dig_upd = 1'b1;
				state_d     = msth_pkg::S_DIG;
			end
			msth_pkg::S_LA: begin
				state_d = msth_pkg::S_LB;
			end
			msth_pkg::S_LB: begin
				cmd.cap_a = 1'b1;
				cmd.rd_b  = 1'b1;
				state_d   = msth_pkg::S_LW;
			end
			msth_pkg::S_LW: begin
				cmd.cap_b = 1'b1;
				state_d   = search_q ? msth_pkg::S_SRD : msth_pkg::S_INS;
			end
			msth_pkg::S_INS: begin
				cmd.insert = 1'b1;
				state_d    = msth_pkg::S_OUT;
			end
			msth_pkg::S_SRD: begin
				state_d = msth_pkg::S_SCMP;
			end
			msth_pkg::S_SCMP: begin
				cmd.scmp = 1'b1;
				if (sts.hit || sts.step_last) begin
					state_d = msth_pkg::S_OUT;
				end else begin
					state_d = msth_pkg::S_SRD;
				end
			end
			msth_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = msth_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = msth_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/msth_chk.sv
// ----------------------------------------------------------------------------
// msth_chk
// Port-level checks of the hash table result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module msth_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// Hold a stalled result word
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Rejected key carries no hash or location
	`CHK_PROP(a_big_zero, clk, arst_n,
		m_tvalid && m_tdata[2:0] == msth_pkg::ST_BIG |-> m_tdata[26:3] == '0)
	// Miss and full results carry no location
	`CHK_PROP(a_miss_zero, clk, arst_n,
		m_tvalid && (m_tdata[2:0] == msth_pkg::ST_MISS || m_tdata[2:0] == msth_pkg::ST_FULL)
		|-> m_tdata[26:13] == '0)
	// Hash stays below 1000 and pad bits stay zero
	`CHK_PROP(a_hash_range, clk, arst_n,
		m_tvalid |-> m_tdata[12:3] < 10'd1000 && m_tdata[31:27] == '0)

endmodule

bind mid_square_two_choice_hash_table msth_chk u_msth_chk (.*);

`default_nettype wire

FILE: test/mid_square_two_choice_hash_table_test.sv
// ----------------------------------------------------------------------------
// mid_square_two_choice_hash_table_test
// Self-checking bench for the mid-square two-choice key table. A queue-fed
// driver offers insert and search words, an in-bench table model predicts
// each status and location, and a monitor compares every result word with the
// oldest prediction. The run walks through several bucket pair counts and
// several idle and stall mixes on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_square_two_choice_hash_table_test;

	typedef struct packed {
		logic                      search;
		logic [msth_pkg::KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		msth_pkg::status_t           st;
		logic [msth_pkg::HASH_W-1:0] hash;
		logic [msth_pkg::BKT_W-1:0]  bucket;
		logic [msth_pkg::POS_W-1:0]  slot;
	} lookup_t;

	typedef logic [msth_pkg::LEN_W-1:0] len_t;

	localparam int DEPTH = 8;
	localparam int DRAIN_CYCLES = 100;
	localparam int LONG_HOLD = 600;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [31:0]      m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [9:0]       cfg_data;

	// bench copy of the table
	logic [msth_pkg::KEY_W-1:0]  key_mem [msth_pkg::NSLOTS];
	len_t                        len_mem [msth_pkg::NBUCKETS];
	logic [msth_pkg::PAIR_W-1:0] pairs_reg;

	req_t    req_q [$];
	lookup_t lookup_q [$];
	int      key_pool [$];

	int src_pct, snk_pct;
	int hold_cnt, hold_reqs, hold_seen;
	int cfg_writes, n_sent, n_checked, n_errors, n_full, n_found, n_big;
	bit word_taken;

	mid_square_two_choice_hash_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned digit_count(input longint unsigned v);
		int unsigned n;
		n = 0;
		while (v > 0) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

	function automatic int unsigned eff_pairs(input logic [msth_pkg::PAIR_W-1:0] r);
		int unsigned s;
		s = r;
		if (s % 2 == 0)
			s = s + 1;
		if (s > 1024)
			s = 1024;
		return s;
	endfunction

	function automatic int unsigned mid_square(input int unsigned key,
		input int unsigned pairs);
		int unsigned nd, nsq, drop, modv;
		longint unsigned sq;
		nd = digit_count(pairs);
		sq = longint'(key) * key;
		nsq = digit_count(sq);
		modv = 1;
		drop = 0;
		for (int i = 1; i < nd; i++)
			modv = modv * 10;
		if (nsq > nd)
			drop = nsq - nd;
		if (drop % 2 == 1)
			drop++;
		for (int i = 0; i < drop / 2; i++)
			sq = sq / 10;
		return int'(sq % modv);
	endfunction

	// Apply one request to the bench table and queue its expected lookup
	task automatic predict_lookup(input req_t r);
		lookup_t e;
		int unsigned pairs, h, a, b, idx, pos;
		e = '{st: msth_pkg::ST_INS, hash: '0, bucket: '0, slot: '0};
		if (r.key > msth_pkg::KEY_LIMIT) begin
			e.st = msth_pkg::ST_BIG;
		end else begin
			pairs = eff_pairs(pairs_reg);
			h = mid_square(r.key, pairs);
			a = h;
			b = h + pairs;
			e.hash = h[msth_pkg::HASH_W-1:0];
			if (!r.search) begin
				if (len_mem[a] == 0)
					idx = a;
				else if (len_mem[b] == 0)
					idx = b;
				else
					idx = (len_mem[a] > len_mem[b]) ? b : a;
				pos = len_mem[idx];
				if (pos >= DEPTH) begin
					e.st = msth_pkg::ST_FULL;
				end else begin
					key_mem[idx * DEPTH + pos] = r.key;
					len_mem[idx] = len_t'(pos + 1);
					e.bucket = idx[msth_pkg::BKT_W-1:0];
					e.slot = pos[msth_pkg::POS_W-1:0];
				end
			end else begin
				e.st = msth_pkg::ST_MISS;
				for (int p = 0; p < DEPTH; p++) begin
					if (p < len_mem[a] && key_mem[a * DEPTH + p] == r.key) begin
						e.st = msth_pkg::ST_FOUND;
						e.bucket = a[msth_pkg::BKT_W-1:0];
						e.slot = p[msth_pkg::POS_W-1:0];
						break;
					end
					if (p < len_mem[b] && key_mem[b * DEPTH + p] == r.key) begin
						e.st = msth_pkg::ST_FOUND;
						e.bucket = b[msth_pkg::BKT_W-1:0];
						e.slot = p[msth_pkg::POS_W-1:0];
						break;
					end
				end
			end
		end
		lookup_q.push_back(e);
	endtask

	// Sample accepted words on both sides and check results
	always @(posedge clk) begin
		lookup_t e, got;
		word_taken = s_tvalid && s_tready;
		if (arst_n && cfg_valid && cfg_ready) begin
			pairs_reg = cfg_data;
			cfg_writes++;
		end
		if (arst_n && word_taken)
			predict_lookup('{search: s_tuser, key: s_tdata});
		if (arst_n && m_tvalid && m_tready) begin
			got = '{st: msth_pkg::status_t'(m_tdata[2:0]), hash: m_tdata[12:3],
				bucket: m_tdata[23:13], slot: m_tdata[26:24]};
			if (lookup_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				e = lookup_q.pop_front();
				n_checked++;
				if (e.st == msth_pkg::ST_FULL)
					n_full++;
				if (e.st == msth_pkg::ST_FOUND)
					n_found++;
				if (e.st == msth_pkg::ST_BIG)
					n_big++;
				if (got != e) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch: exp st=%0d h=%0d b=%0d p=%0d, ",
							"got st=%0d h=%0d b=%0d p=%0d"},
							e.st, e.hash, e.bucket, e.slot,
							got.st, got.hash, got.bucket, got.slot);
				end
			end
		end
	end

	// Offer queued words, idling at the configured rate
	always @(negedge clk) begin
		req_t r;
		if (!s_tvalid || word_taken) begin
			if (req_q.size() > 0 && $urandom_range(99) >= src_pct) begin
				r = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.search;
				s_tdata <= r.key;
				n_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_cnt <= LONG_HOLD;
			hold_seen <= hold_reqs;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Drive result ready with random stalls
	always @(negedge clk) begin
		m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_pct);
	end

	task automatic push_req(input bit search, input int key);
		req_q.push_back('{search: search, key: key[msth_pkg::KEY_W-1:0]});
		if (!search && key <= msth_pkg::KEY_LIMIT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 64)
				void'(key_pool.pop_front());
		end
	endtask

	// Wait until every word is sent and answered, then let the block settle
	task automatic drain();
		while (req_q.size() > 0 || s_tvalid || lookup_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pairs(input logic [msth_pkg::PAIR_W-1:0] v);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		while (cfg_writes == seen)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_reqs(input int n);
		int k, u;
		for (int i = 0; i < n; i++) begin
			u = $urandom_range(99);
			if (u < 8) begin
				push_req($urandom_range(1) != 0, $urandom_range(65535));
			end else if (u < 50) begin
				k = ($urandom_range(3) == 0) ? $urandom_range(46340, 46000)
					: $urandom_range(46340);
				push_req(1'b0, k);
			end else if (u < 85 && key_pool.size() > 0) begin
				push_req(1'b1, key_pool[$urandom_range(key_pool.size() - 1)]);
			end else begin
				push_req(1'b1, $urandom_range(46340));
			end
		end
	endtask

	task automatic run_phase(input logic [msth_pkg::PAIR_W-1:0] pairs, input int sp,
		input int kp, input int n, input bit hold);
		write_pairs(pairs);
		src_pct = sp;
		snk_pct = kp;
		if (hold)
			hold_reqs++;
		random_reqs(n / 2);
		// let the table empty its pipeline before the second half
		drain();
		random_reqs(n - n / 2);
		drain();
	endtask

	initial begin
		for (int i = 0; i < msth_pkg::NBUCKETS; i++)
			len_mem[i] = '0;
		pairs_reg = msth_pkg::PAIRS_RESET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		src_pct = 0;
		snk_pct = 0;
		hold_cnt = 0;
		hold_reqs = 0;
		hold_seen = 0;
		word_taken = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: key range edges, duplicates and misses at reset geometry
		push_req(1'b0, 0);
		push_req(1'b0, 46340);
		push_req(1'b0, 46341);
		push_req(1'b1, 65535);
		push_req(1'b1, 0);
		push_req(1'b1, 46340);
		push_req(1'b1, 12345);
		push_req(1'b0, 0);
		push_req(1'b1, 0);
		drain();
		// one pair: every key lands on hash zero, fill both chains past full
		write_pairs(10'd1);
		for (int i = 0; i < 17; i++)
			push_req(1'b0, 7 + i);
		push_req(1'b1, 22);
		drain();

		run_phase(10'd11, 0, 0, 300, 1'b0);
		run_phase(10'd1023, 67, 0, 300, 1'b0);
		run_phase(10'd0, 0, 67, 300, 1'b0);
		run_phase(10'd100, 37, 37, 300, 1'b0);
		run_phase(10'd1022, 0, 0, 300, 1'b1);
		run_phase(10'd5, 67, 67, 300, 1'b0);

		$display("sent %0d words, checked %0d results over %0d table settings",
			n_sent, n_checked, cfg_writes);
		$display("outcomes seen: %0d found, %0d chain full, %0d too large",
			n_found, n_full, n_big);
		if (n_errors == 0 && lookup_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
